// ===== design/servo_bus_status_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// Servo bus status deframer assertion macros
// Shared concurrent assertion wrappers for the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef SERVO_BUS_STATUS_DEFRAMER_DEFINES_SVH
`define SERVO_BUS_STATUS_DEFRAMER_DEFINES_SVH

// implication check, sampled on the rising clock, off while in reset
`define SVBSD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define SVBSD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/svbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo bus status deframer package
// Field widths, protocol constants, result codes and the result record.
// ----------------------------------------------------------------------------
package svbsd_pkg;

	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int FIELDS_W = 4 * BYTE_W + STATUS_W;
	localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
	localparam int PAD_W    = TDATA_W - FIELDS_W;

	localparam logic [BYTE_W-1:0] HDR_BYTE     = 8'hFF;
	localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_ID       = 2'd2,
		ST_SHORT    = 2'd3
	} pkt_status_t;

	typedef enum logic {
		KIND_PARAM  = 1'b0,
		KIND_STATUS = 1'b1
	} res_kind_t;

	// tdata fields, lowest bits last
	typedef struct packed {
		logic [BYTE_W-1:0] param_count;
		logic [BYTE_W-1:0] servo_error_bits;
		pkt_status_t       packet_status;
		logic [BYTE_W-1:0] param_value;
		logic [BYTE_W-1:0] param_index;
	} res_fields_t;

	typedef struct packed {
		res_kind_t   result_kind;
		res_fields_t fields;
	} res_t;

	// input stage to parser
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] rx_byte;
	} in_req_t;

endpackage

// ===== design/svbsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Servo bus status deframer input stage
// Registers one received byte request ahead of the parser.
// ----------------------------------------------------------------------------
module svbsd_in_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [svbsd_pkg::BYTE_W-1:0] s_axis_tdata,
	input  logic                       pipe_ready,
	output svbsd_pkg::in_req_t         req
);
	import svbsd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;

	assign s_axis_tready = !valid_s1 || pipe_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			rx_byte_s1 <= s_axis_tdata;
		end
	end

	assign req.valid   = valid_s1;
	assign req.rx_byte = rx_byte_s1;

endmodule

// ===== design/svbsd_parser.sv =====
// ----------------------------------------------------------------------------
// Servo bus status deframer parser
// Packet state machine, running checksum and result formation per byte.
// ----------------------------------------------------------------------------
module svbsd_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [svbsd_pkg::BYTE_W-1:0] cfg_wr_data,
	input  svbsd_pkg::in_req_t           req,
	input  logic                         pipe_ready,
	output logic                         res_valid,
	output svbsd_pkg::res_t              res
);
	import svbsd_pkg::*;

	typedef enum logic [6:0] {
		PH_HUNT1 = 7'b0000001,
		PH_HUNT2 = 7'b0000010,
		PH_ID    = 7'b0000100,
		PH_LEN   = 7'b0001000,
		PH_ERR   = 7'b0010000,
		PH_PARAM = 7'b0100000,
		PH_CHK   = 7'b1000000
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] exp_id_q;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] err_q, err_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] seen_q, seen_d;
	logic              idm_q, idm_d;
	logic [BYTE_W-1:0] nparams;
	logic [BYTE_W-1:0] seen_inc;
	logic [BYTE_W-1:0] b;
	logic              step;
	logic              emit;

	assign b    = req.rx_byte;
	assign step = req.valid && pipe_ready;

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		err_d    = err_q;
		sum_d    = sum_q;
		seen_d   = seen_q;
		idm_d    = idm_q;
		emit     = 1'b0;
		nparams  = len_q - LEN_OVERHEAD;
		seen_inc = seen_q + 8'd1;
		res                         = '0;
		res.result_kind             = KIND_PARAM;
		res.fields.packet_status    = ST_OK;
		res.fields.servo_error_bits = err_q;
		unique case (phase_q)
			PH_HUNT1: begin
				phase_d = (b == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
			end
			PH_HUNT2: begin
				phase_d = (b == HDR_BYTE) ? PH_ID : PH_HUNT1;
			end
			PH_ID: begin
				idm_d   = (b == exp_id_q);
				sum_d   = b;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = b;
				sum_d   = sum_q + b;
				phase_d = PH_ERR;
			end
			PH_ERR: begin
				err_d  = b;
				sum_d  = sum_q + b;
				seen_d = '0;
				res.fields.servo_error_bits = b;
				priority if (!idm_q) begin
					phase_d                  = PH_HUNT1;
					emit                     = 1'b1;
					res.result_kind          = KIND_STATUS;
					res.fields.packet_status = ST_ID;
				end else if (len_q < LEN_OVERHEAD) begin
					phase_d                  = PH_HUNT1;
					emit                     = 1'b1;
					res.result_kind          = KIND_STATUS;
					res.fields.packet_status = ST_SHORT;
				end else if (len_q == LEN_OVERHEAD) begin
					phase_d = PH_CHK;
				end else begin
					phase_d = PH_PARAM;
				end
			end
			PH_PARAM: begin
				emit                   = 1'b1;
				res.fields.param_index = seen_q;
				res.fields.param_value = b;
				sum_d                  = sum_q + b;
				seen_d                 = seen_inc;
				if (seen_inc >= nparams) begin
					phase_d = PH_CHK;
				end
			end
			PH_CHK: begin
				phase_d                  = PH_HUNT1;
				emit                     = 1'b1;
				res.result_kind          = KIND_STATUS;
				res.fields.packet_status = (b == ~sum_q) ? ST_OK : ST_CHECKSUM;
				res.fields.param_count   = nparams;
			end
			default: begin
				phase_d = (b == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
			end
		endcase
	end

	assign res_valid = step && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT1;
			exp_id_q <= '0;
			len_q    <= '0;
			err_q    <= '0;
			sum_q    <= '0;
			seen_q   <= '0;
			idm_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				exp_id_q <= cfg_wr_data;
			end
			if (step) begin
				phase_q <= phase_d;
				len_q   <= len_d;
				err_q   <= err_d;
				sum_q   <= sum_d;
				seen_q  <= seen_d;
				idm_q   <= idm_d;
			end
		end
	end

endmodule

// ===== design/svbsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Servo bus status deframer output stage
// Result register driving the master stream channel.
// ----------------------------------------------------------------------------
module svbsd_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	input  svbsd_pkg::res_t               res,
	output logic                          pipe_ready,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [svbsd_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tuser
);
	import svbsd_pkg::*;

	logic valid_q;
	res_t res_q;

	assign pipe_ready = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pipe_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, res_q.fields};
	assign m_axis_tuser  = res_q.result_kind;

endmodule

// ===== design/servo_bus_status_deframer.sv =====
// ----------------------------------------------------------------------------
// Servo bus status deframer
// Parses servo status packets from received bus bytes into parameter and
// status results.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata[7:0] rx_byte
//   m_axis    out  tvalid/tready          tuser result_kind, tdata fields
//   cfg       in   cfg_wr_en              cfg_wr_data expected_servo_id
//
// One byte per cycle sustained while the result is not stalled; a request
// passes through the input register and the result register around the parser.
// Reset clears the parser to header hunt and both stages to empty.
// A stalled result holds the parser and input register; a new byte is
// still taken while the result register drains.
// ----------------------------------------------------------------------------
module servo_bus_status_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [svbsd_pkg::BYTE_W-1:0]  cfg_wr_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [svbsd_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [7:0] param_index, [15:8] param_value, [17:16] packet_status,
	// [25:18] servo_error_bits, [33:26] param_count, [39:34] zero
	output logic [svbsd_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tuser   // [0] result_kind
);
	import svbsd_pkg::*;

	in_req_t req;
	res_t    res;
	logic    res_valid;
	logic    pipe_ready;

	svbsd_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.pipe_ready    (pipe_ready),
		.req           (req)
	);

	svbsd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.pipe_ready  (pipe_ready),
		.res_valid   (res_valid),
		.res         (res)
	);

	svbsd_out_stage u_out_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (res_valid),
		.res           (res),
		.pipe_ready    (pipe_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== design/svbsd_checker.sv =====
// ----------------------------------------------------------------------------
// Servo bus status deframer checker
// Port-level checks on result formatting and output stall behavior.
// ----------------------------------------------------------------------------
`include "servo_bus_status_deframer_defines.svh"

module svbsd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [svbsd_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tuser
);
	import svbsd_pkg::*;

	res_fields_t f;
	logic        is_status;
	logic        is_param;

	assign f         = res_fields_t'(m_axis_tdata[FIELDS_W-1:0]);
	assign is_status = m_axis_tvalid && (m_axis_tuser == KIND_STATUS);
	assign is_param  = m_axis_tvalid && (m_axis_tuser == KIND_PARAM);

	`SVBSD_ASSERT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
	`SVBSD_ASSERT_NEVER(a_status_no_param, clk, arst_n, is_status && (f.param_index != '0 || f.param_value != '0), "status result carries parameter fields")
	`SVBSD_ASSERT_NEVER(a_param_clean, clk, arst_n, is_param && (f.packet_status != ST_OK || f.param_count != '0), "parameter result carries status fields")
	`SVBSD_ASSERT_NEVER(a_abort_count, clk, arst_n, is_status && (f.packet_status == ST_ID || f.packet_status == ST_SHORT) && f.param_count != '0, "aborted packet reports parameters")

endmodule

bind servo_bus_status_deframer svbsd_checker u_svbsd_checker (.*);
